>>> src/rotary_encoder_edge_decoder_assert.svh
// Assertion helpers for the rotary encoder edge decoder.
// Both sample on clk and stay quiet while rst is high.
`ifndef ROTARY_ENCODER_EDGE_DECODER_ASSERT_SVH
`define ROTARY_ENCODER_EDGE_DECODER_ASSERT_SVH

// Condition that must hold at every edge.
`define RED_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("rotary encoder edge decoder: check failed");

// Consequent that must hold in the same cycle as the antecedent.
`define RED_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rotary encoder edge decoder: implication failed");

`endif

>>> src/red_pkg.sv
package red_pkg;

  localparam int NUM_ENCODERS_DEFAULT = 16;
  localparam int TIME_BITS_DEFAULT    = 32;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [31:0] ROTATE_HOLDOFF_RESET = 32'd50000;
  localparam logic [31:0] CLICK_HOLDOFF_RESET  = 32'd200000;

  // Pin codes of an incoming event
  localparam logic [1:0] KIND_A     = 2'd0;
  localparam logic [1:0] KIND_B     = 2'd1;
  localparam logic [1:0] KIND_CLICK = 2'd2;

  // Reported event codes
  localparam logic [1:0] EV_CCW   = 2'd0;
  localparam logic [1:0] EV_CW    = 2'd1;
  localparam logic [1:0] EV_CLICK = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic [0:0] REG_ROTATE = 1'b0;
  localparam logic [0:0] REG_CLICK  = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  switch_index;
    logic        level_a;
    logic        level_b;
    logic [31:0] now_us;
  } in_t;

  typedef struct packed {
    logic [3:0] source_switch;
    logic [1:0] event_code;
  } out_t;

  typedef enum logic [1:0] {
    OP_FALL_A,
    OP_FALL_B,
    OP_CLICK
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t     op;
    logic [3:0]  sw;
    logic        level_a;
    logic        level_b;
    logic [31:0] now_us;
  } cmd_t;

  typedef struct packed {
    logic [31:0] rotate_holdoff_us;
    logic [31:0] click_holdoff_us;
  } cfg_t;

endpackage

>>> src/red_fifo.sv
module red_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = red_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t wdata,
  output logic  full,
  input  logic  pop,
  output item_t rdata,
  output logic  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    advance = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= advance(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= advance(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> src/red_front.sv
module red_front #(
  parameter int NUM_ENCODERS = red_pkg::NUM_ENCODERS_DEFAULT
) (
  input  logic          push,
  input  red_pkg::in_t  item,
  output logic          full,
  input  logic          cmd_full,
  output logic          cmd_push,
  output red_pkg::cmd_t cmd
);

  logic keep;
  logic sw_ok;

  assign sw_ok = ({28'b0, item.switch_index} < 32'(NUM_ENCODERS));

  always_comb begin
    keep   = 1'b1;
    cmd.op = red_pkg::OP_CLICK;
    unique case (item.kind)
      red_pkg::KIND_A:     cmd.op = red_pkg::OP_FALL_A;
      red_pkg::KIND_B:     cmd.op = red_pkg::OP_FALL_B;
      red_pkg::KIND_CLICK: cmd.op = red_pkg::OP_CLICK;
      default:             keep   = 1'b0;
    endcase
    cmd.sw      = item.switch_index;
    cmd.level_a = item.level_a;
    cmd.level_b = item.level_b;
    cmd.now_us  = item.now_us;
  end

  // Accept every request while the queue has room; drop the ones that can never report.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && keep && sw_ok;

endmodule

>>> src/red_back.sv
module red_back #(
  parameter int NUM_ENCODERS = red_pkg::NUM_ENCODERS_DEFAULT,
  parameter int TIME_BITS    = red_pkg::TIME_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  red_pkg::cfg_t cfg,
  input  logic          cmd_empty,
  input  red_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output red_pkg::out_t res
);

  localparam int ENTRIES = (NUM_ENCODERS < 16) ? NUM_ENCODERS : 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CMP_W   = (TIME_BITS > 32) ? TIME_BITS : 32;

  logic [TIME_BITS-1:0] last_time [ENTRIES];
  logic                 cw_armed  [ENTRIES];
  logic                 ccw_armed [ENTRIES];

  logic [IDX_W-1:0]     idx;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 click_ok;
  logic                 rot_ok;
  logic                 fire;
  logic                 emit;
  logic                 stamp;
  logic                 cw_next;
  logic                 ccw_next;
  logic [1:0]           code;
  logic                 both_low;

  assign idx      = IDX_W'(cmd.sw);
  assign now_t    = TIME_BITS'(cmd.now_us);
  assign elapsed  = now_t - last_time[idx];
  assign click_ok = CMP_W'(elapsed) >= CMP_W'(cfg.click_holdoff_us);
  assign rot_ok   = CMP_W'(elapsed) >= CMP_W'(cfg.rotate_holdoff_us);
  assign fire     = !cmd_empty && !res_full;
  assign cmd_pop  = fire;
  assign both_low = !cmd.level_a && !cmd.level_b;

  always_comb begin
    emit     = 1'b0;
    stamp    = 1'b0;
    code     = red_pkg::EV_CLICK;
    cw_next  = cw_armed[idx];
    ccw_next = ccw_armed[idx];
    case (cmd.op)
      red_pkg::OP_CLICK: begin
        if (click_ok) begin
          emit  = 1'b1;
          stamp = 1'b1;
        end
      end
      red_pkg::OP_FALL_A: begin
        if (rot_ok) begin
          if (cmd.level_b && !cmd.level_a) begin
            cw_next = 1'b1;
          end
          if (ccw_armed[idx] && both_low) begin
            cw_next  = 1'b0;
            ccw_next = 1'b0;
            emit     = 1'b1;
            stamp    = 1'b1;
            code     = red_pkg::EV_CCW;
          end
        end
      end
      red_pkg::OP_FALL_B: begin
        if (rot_ok) begin
          if (cmd.level_a && !cmd.level_b) begin
            ccw_next = 1'b1;
          end
          if (cw_armed[idx] && both_low) begin
            cw_next  = 1'b0;
            ccw_next = 1'b0;
            emit     = 1'b1;
            stamp    = 1'b1;
            code     = red_pkg::EV_CW;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  assign res_push          = fire && emit;
  assign res.source_switch = cmd.sw;
  assign res.event_code    = code;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        last_time[i] <= '0;
        cw_armed[i]  <= 1'b0;
        ccw_armed[i] <= 1'b0;
      end
    end else if (fire) begin
      cw_armed[idx]  <= cw_next;
      ccw_armed[idx] <= ccw_next;
      if (stamp) begin
        last_time[idx] <= now_t;
      end
    end
  end

endmodule

>>> src/rotary_encoder_edge_decoder.sv
// Rotary encoder edge decoder: takes falling-edge events from up to sixteen encoders
// with push buttons, debounces them against the per-encoder time of the last
// reported event, and reports counterclockwise, clockwise and click events through
// a result queue. One event is accepted per clock cycle when neither side stalls;
// that rate is set by the back stage, which does the per-encoder state
// read-modify-write for one event a cycle. A reported event passes through the
// command queue, where the back stage takes it from the head, and then through the
// result queue before it shows on the result ports; either queue can hold it while
// the side after it stalls. Events that cannot report (unused pin code, encoder out of
// range) are dropped on entry. Hold-off registers sit at byte address 0 (rotate)
// and 4 (click) and must only be written while the block is idle.
`include "rotary_encoder_edge_decoder_assert.svh"

module rotary_encoder_edge_decoder #(
  parameter int NUM_ENCODERS = red_pkg::NUM_ENCODERS_DEFAULT,
  parameter int TIME_BITS    = red_pkg::TIME_BITS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  red_pkg::in_t  item,
  output logic          full,
  input  logic          pop,
  output red_pkg::out_t result,
  output logic          empty,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  red_pkg::cfg_t cfg;
  logic          cfg_write;

  logic          cmd_push;
  logic          cmd_full;
  logic          cmd_pop;
  logic          cmd_empty;
  red_pkg::cmd_t cmd_in;
  red_pkg::cmd_t cmd_head;

  logic          res_push;
  logic          res_full;
  red_pkg::out_t res_in;
  logic          res_is_click;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotate_holdoff_us <= red_pkg::ROTATE_HOLDOFF_RESET;
      cfg.click_holdoff_us  <= red_pkg::CLICK_HOLDOFF_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        red_pkg::REG_ROTATE: cfg.rotate_holdoff_us <= pwdata;
        red_pkg::REG_CLICK:  cfg.click_holdoff_us  <= pwdata;
        default:             cfg.click_holdoff_us  <= cfg.click_holdoff_us;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      red_pkg::REG_ROTATE: prdata = cfg.rotate_holdoff_us;
      default:             prdata = cfg.click_holdoff_us;
    endcase
  end

  red_front #(
    .NUM_ENCODERS(NUM_ENCODERS)
  ) u_front (
    .push    (push),
    .item    (item),
    .full    (full),
    .cmd_full(cmd_full),
    .cmd_push(cmd_push),
    .cmd     (cmd_in)
  );

  red_fifo #(
    .item_t(red_pkg::cmd_t),
    .DEPTH (red_pkg::QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_push),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  red_back #(
    .NUM_ENCODERS(NUM_ENCODERS),
    .TIME_BITS   (TIME_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  red_fifo #(
    .item_t(red_pkg::out_t),
    .DEPTH (red_pkg::QUEUE_DEPTH)
  ) u_res_queue (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(result),
    .empty(empty)
  );

  assign res_is_click = (res_in.event_code == red_pkg::EV_CLICK);

  // A result only comes from the command being retired, never into a full queue.
  `RED_ASSERT(res_no_overflow, !(res_push && res_full))
  `RED_ASSERT_IMPLIES(res_needs_cmd, res_push, cmd_pop)
  `RED_ASSERT_IMPLIES(res_switch_match, res_push, res_in.source_switch == cmd_head.sw)
  `RED_ASSERT_IMPLIES(click_from_click, res_push && res_is_click, cmd_head.op == red_pkg::OP_CLICK)

endmodule
